// ----- rtl/core/sse_line_field_parser_top_assert.svh -----
// Assertion macros for the line field parser top level.
`ifndef SSE_LINE_FIELD_PARSER_TOP_ASSERT_SVH
`define SSE_LINE_FIELD_PARSER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SSELFP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("sselfp assertion failed");

// Check cons in the cycle after ante.
`define SSELFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("sselfp assertion failed");

`endif

// ----- rtl/core/sselfp_pkg.sv -----
// Types, codes and field name tables for the line field parser.
package sselfp_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [2:0] KIND_DATA_BYTE = 3'd0;
    localparam logic [2:0] KIND_TYPE_CLR  = 3'd1;
    localparam logic [2:0] KIND_TYPE_BYTE = 3'd2;
    localparam logic [2:0] KIND_ID_CLR    = 3'd3;
    localparam logic [2:0] KIND_ID_BYTE   = 3'd4;
    localparam logic [2:0] KIND_DISPATCH  = 3'd5;

    localparam int NUM_NAMES = 4;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_CW      = $clog2(Q_DEPTH + 1);

    // Name indexes: data, event, id, retry.
    localparam logic [1:0] NM_DATA  = 2'd0;
    localparam logic [1:0] NM_EVENT = 2'd1;
    localparam logic [1:0] NM_ID    = 2'd2;
    localparam logic [1:0] NM_RETRY = 2'd3;

    typedef enum logic [1:0] {
        PH_START,
        PH_NAME,
        PH_VALUE,
        PH_IGNORE
    } phase_t;

    typedef enum logic [1:0] {
        TG_NONE,
        TG_DATA,
        TG_EVENT,
        TG_ID
    } target_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } parse_out_t;

    function automatic logic [2:0] name_len(input logic [1:0] idx);
        logic [2:0] len;
        case (idx)
            NM_DATA:  len = 3'd4;
            NM_EVENT: len = 3'd5;
            NM_ID:    len = 3'd2;
            NM_RETRY: len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] name_char(input logic [1:0] idx, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (idx)
            NM_DATA: begin
                case (pos)
                    3'd0: ch = "d";
                    3'd1: ch = "a";
                    3'd2: ch = "t";
                    3'd3: ch = "a";
                    default: ch = 8'h00;
                endcase
            end
            NM_EVENT: begin
                case (pos)
                    3'd0: ch = "e";
                    3'd1: ch = "v";
                    3'd2: ch = "e";
                    3'd3: ch = "n";
                    3'd4: ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            NM_ID: begin
                case (pos)
                    3'd0: ch = "i";
                    3'd1: ch = "d";
                    default: ch = 8'h00;
                endcase
            end
            NM_RETRY: begin
                case (pos)
                    3'd0: ch = "r";
                    3'd1: ch = "e";
                    3'd2: ch = "t";
                    3'd3: ch = "r";
                    3'd4: ch = "y";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] value_kind(input target_t tgt);
        logic [2:0] k;
        case (tgt)
            TG_DATA:  k = KIND_DATA_BYTE;
            TG_EVENT: k = KIND_TYPE_BYTE;
            default:  k = KIND_ID_BYTE;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/core/sse_line_field_parser_top.sv -----
// Top level of the event-stream line field parser.
//
//  channel | prefix | payload                               | dir
//  request | s_     | s_in_byte                             | in
//  result  | m_     | m_out_kind, m_out_byte, m_out_last    | out
//
// A byte is registered on acceptance and parsed from that register into zero,
// one or two results that enter a four-entry result queue.
// One byte per cycle is taken while results drain as fast as they are made;
// a byte that gives two results sends them in turn on the single result port.
// Reset (aresetn low, synchronous) returns to line start with no data present.
// A stalled result port fills the queue; then the input register holds its byte
// and s_ready drops.
module sse_line_field_parser_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_out_kind,
    output logic [7:0] m_out_byte,
    output logic       m_out_last
);

    `include "sse_line_field_parser_top_assert.svh"

    logic                          in_valid_reg;
    logic [7:0]                    in_byte_reg;
    logic                          advance;
    logic                          q_room;
    logic [sselfp_pkg::Q_CW-1:0]   q_count;
    sselfp_pkg::parse_out_t        parsed;
    sselfp_pkg::result_t           q_head;

    assign advance = in_valid_reg && q_room;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_in_byte;
        end
    end

    sselfp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_byte (in_byte_reg),
        .res     (parsed)
    );

    sselfp_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (parsed),
        .push_en   (advance),
        .pop       (m_ready),
        .room      (q_room),
        .not_empty (m_valid),
        .head      (q_head),
        .count     (q_count)
    );

    assign m_out_kind = q_head.kind;
    assign m_out_byte = q_head.data;
    assign m_out_last = q_head.last;

    `SSELFP_ASSERT_NOW(a_clear_zero_byte,
        m_valid && (m_out_kind == sselfp_pkg::KIND_TYPE_CLR ||
                    m_out_kind == sselfp_pkg::KIND_ID_CLR ||
                    m_out_kind == sselfp_pkg::KIND_DISPATCH),
        m_out_byte == 8'h00)
    `SSELFP_ASSERT_NOW(a_queue_bound, 1'b1,
        q_count <= sselfp_pkg::Q_CW'(sselfp_pkg::Q_DEPTH))
    `SSELFP_ASSERT_NEXT(a_input_hold, in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg))

endmodule

// ----- rtl/core/sselfp_parse.sv -----
// Line state registers and per-byte field parsing logic.
module sselfp_parse (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic [7:0]             in_byte,
    output sselfp_pkg::parse_out_t res
);

    sselfp_pkg::phase_t  phase_reg, phase_next;
    logic [2:0]          pos_reg, pos_next;
    logic [3:0]          cand_reg, cand_next;
    sselfp_pkg::target_t tgt_reg, tgt_next;
    logic                first_reg, first_next;
    logic                held_reg, held_next;
    logic                dp_reg, dp_next;
    logic [3:0]          len_hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= sselfp_pkg::PH_START;
            pos_reg   <= 3'd0;
            cand_reg  <= 4'hF;
            tgt_reg   <= sselfp_pkg::TG_NONE;
            first_reg <= 1'b0;
            held_reg  <= 1'b0;
            dp_reg    <= 1'b0;
        end else if (advance) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            cand_reg  <= cand_next;
            tgt_reg   <= tgt_next;
            first_reg <= first_next;
            held_reg  <= held_next;
            dp_reg    <= dp_next;
        end
    end

    always_comb begin
        for (int i = 0; i < sselfp_pkg::NUM_NAMES; i++) begin
            len_hit[i] = cand_reg[i] && (sselfp_pkg::name_len(2'(i)) == pos_reg);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        tgt_next   = tgt_reg;
        first_next = first_reg;
        held_next  = held_reg;
        dp_next    = dp_reg;
        res        = '0;

        if (in_byte == sselfp_pkg::CH_LF) begin
            if (phase_reg == sselfp_pkg::PH_START && dp_reg) begin
                res.cnt     = 2'd1;
                res.r0.kind = sselfp_pkg::KIND_DISPATCH;
                dp_next     = 1'b0;
            end
            phase_next = sselfp_pkg::PH_START;
            pos_next   = 3'd0;
            cand_next  = 4'hF;
            tgt_next   = sselfp_pkg::TG_NONE;
            first_next = 1'b0;
            held_next  = 1'b0;
        end else begin
            case (phase_reg)
                sselfp_pkg::PH_START, sselfp_pkg::PH_NAME: begin
                    if (phase_reg == sselfp_pkg::PH_START && held_reg) begin
                        held_next  = 1'b0;
                        phase_next = sselfp_pkg::PH_IGNORE;
                    end else if (phase_reg == sselfp_pkg::PH_START &&
                                 in_byte == sselfp_pkg::CH_CR) begin
                        held_next = 1'b1;
                    end else if (in_byte == sselfp_pkg::CH_COLON) begin
                        phase_next = sselfp_pkg::PH_VALUE;
                        first_next = 1'b1;
                        if (len_hit[sselfp_pkg::NM_RETRY]) begin
                            phase_next = sselfp_pkg::PH_IGNORE;
                            first_next = 1'b0;
                        end else if (len_hit[sselfp_pkg::NM_ID]) begin
                            tgt_next    = sselfp_pkg::TG_ID;
                            res.cnt     = 2'd1;
                            res.r0.kind = sselfp_pkg::KIND_ID_CLR;
                        end else if (len_hit[sselfp_pkg::NM_EVENT]) begin
                            tgt_next    = sselfp_pkg::TG_EVENT;
                            res.cnt     = 2'd1;
                            res.r0.kind = sselfp_pkg::KIND_TYPE_CLR;
                        end else if (len_hit[sselfp_pkg::NM_DATA]) begin
                            tgt_next = sselfp_pkg::TG_DATA;
                            if (dp_reg) begin
                                res.cnt     = 2'd1;
                                res.r0.kind = sselfp_pkg::KIND_DATA_BYTE;
                                res.r0.data = sselfp_pkg::CH_LF;
                            end
                        end else begin
                            phase_next = sselfp_pkg::PH_IGNORE;
                            first_next = 1'b0;
                        end
                    end else begin
                        phase_next = sselfp_pkg::PH_NAME;
                        for (int i = 0; i < sselfp_pkg::NUM_NAMES; i++) begin
                            if (pos_reg >= sselfp_pkg::name_len(2'(i)) ||
                                sselfp_pkg::name_char(2'(i), pos_reg) != in_byte) begin
                                cand_next[i] = 1'b0;
                            end
                        end
                        if (pos_reg != 3'd7) begin
                            pos_next = pos_reg + 3'd1;
                        end
                        if (cand_next == 4'h0) begin
                            phase_next = sselfp_pkg::PH_IGNORE;
                        end
                    end
                end
                sselfp_pkg::PH_VALUE: begin
                    first_next = 1'b0;
                    if (!(first_reg && in_byte == sselfp_pkg::CH_SPACE)) begin
                        if (held_reg) begin
                            held_next   = 1'b0;
                            res.cnt     = 2'd1;
                            res.r0.kind = sselfp_pkg::value_kind(tgt_reg);
                            res.r0.data = sselfp_pkg::CH_CR;
                            if (tgt_reg == sselfp_pkg::TG_DATA) begin
                                dp_next = 1'b1;
                            end
                        end
                        if (in_byte == sselfp_pkg::CH_CR) begin
                            held_next = 1'b1;
                        end else begin
                            if (tgt_reg == sselfp_pkg::TG_DATA) begin
                                dp_next = 1'b1;
                            end
                            if (held_reg) begin
                                res.cnt     = 2'd2;
                                res.r1.kind = sselfp_pkg::value_kind(tgt_reg);
                                res.r1.data = in_byte;
                            end else begin
                                res.cnt     = 2'd1;
                                res.r0.kind = sselfp_pkg::value_kind(tgt_reg);
                                res.r0.data = in_byte;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        res.r0.last = (res.cnt == 2'd1);
        res.r1.last = (res.cnt == 2'd2);
    end

endmodule

// ----- rtl/core/sselfp_outq.sv -----
// Small result queue that takes up to two results per cycle and drains one.
module sselfp_outq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sselfp_pkg::parse_out_t         push,
    input  logic                           push_en,
    input  logic                           pop,
    output logic                           room,
    output logic                           not_empty,
    output sselfp_pkg::result_t            head,
    output logic [sselfp_pkg::Q_CW-1:0]    count
);

    sselfp_pkg::result_t             q_mem [sselfp_pkg::Q_DEPTH];
    logic [sselfp_pkg::Q_AW-1:0]     wp_reg, wp_next;
    logic [sselfp_pkg::Q_AW-1:0]     rp_reg, rp_next;
    logic [sselfp_pkg::Q_CW-1:0]     cnt_reg, cnt_next;
    logic [1:0]                      n_push;
    logic                            do_pop;

    assign n_push    = push_en ? push.cnt : 2'd0;
    assign do_pop    = pop && (cnt_reg != '0);
    assign room      = cnt_reg <= sselfp_pkg::Q_CW'(sselfp_pkg::Q_DEPTH - 2);
    assign not_empty = cnt_reg != '0;
    assign head      = q_mem[rp_reg];
    assign count     = cnt_reg;

    always_comb begin
        wp_next  = wp_reg + sselfp_pkg::Q_AW'(n_push);
        rp_next  = rp_reg + sselfp_pkg::Q_AW'(do_pop);
        cnt_next = cnt_reg + sselfp_pkg::Q_CW'(n_push) - sselfp_pkg::Q_CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            q_mem[wp_reg] <= push.r0;
        end
        if (n_push == 2'd2) begin
            q_mem[wp_reg + sselfp_pkg::Q_AW'(1)] <= push.r1;
        end
    end

endmodule
